// ===== rtl/core/ppc_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the pair collision block.
`timescale 1ns / 1ps
package ppc_pkg;

	localparam int MAX_PARTICLES = 4096;
	localparam int ADDR_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int IDX_W = 12;
	localparam int CD_W = 31;
	localparam int REST_W = 17;

	localparam logic REG_CD = 1'b0;
	localparam logic REG_REST = 1'b1;

	localparam logic [CD_W-1:0] CD_RESET = 31'd83886;
	localparam logic [REST_W-1:0] REST_RESET = 17'd13107;

	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_COLLIDE = 2'd1,
		REQ_READ    = 2'd2
	} req_t;

	typedef struct packed {
		req_t req_type;
		logic fluid_i;
		logic fluid_j;
		logic near;
		logic r2_ok;
		logic sqrt_done;
		logic div_done;
		logic cnt_two;
		logic cnt_last;
		logic vn_neg;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic load;
		logic addr_j;
		logic wr_req;
		logic wr_vel;
		logic cap_i;
		logic cap_j;
		logic diff;
		logic cnt_clr;
		logic cnt_inc;
		logic sq;
		logic sqrt_start;
		logic div_start;
		logic dot;
		logic imp;
		logic imp_latch;
		logic dv;
		logic upd;
		logic out_load;
	} cmd_t;

endpackage

// ===== rtl/core/particle_pair_collision.sv =====
// Top level of the particle pair collision block: register port, controller and datapath.
//
// Channel   Direction  Handshake                  Content
// config    in/out     psel, penable, pready      collision_distance, restitution
// request   in         in_valid / in_ready        one write, collide or read request
// result    out        out_valid / out_ready      velocity of the particle and hit flag
//
// After accept a write passes through S_RDI and S_FIN, a read through S_RDI, S_RDJ and S_FIN.
// A colliding pair is paced by the 32-step square root and three
// 31-step divisions for the unit normal; pairs that are rejected early finish sooner.
// After reset the particle table holds no defined data until written.
// A result waiting in the output register stalls only the end of the next request.
`timescale 1ns / 1ps
module particle_pair_collision (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 req_type,
	input  logic [ppc_pkg::IDX_W-1:0]  particle_index,
	input  logic [ppc_pkg::IDX_W-1:0]  neighbor_index,
	input  logic signed [31:0]         pos_x,
	input  logic signed [31:0]         pos_y,
	input  logic signed [31:0]         pos_z,
	input  logic signed [31:0]         vel_x,
	input  logic signed [31:0]         vel_y,
	input  logic signed [31:0]         vel_z,
	input  logic                       is_fluid,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [31:0]         result_vel_x,
	output logic signed [31:0]         result_vel_y,
	output logic signed [31:0]         result_vel_z,
	output logic                       collided
);

	logic [ppc_pkg::CD_W-1:0]   cd_q;
	logic [ppc_pkg::REST_W-1:0] rest_q;
	logic                       wr_en;
	ppc_pkg::stat_t             status;
	ppc_pkg::cmd_t              cmd;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q   <= ppc_pkg::CD_RESET;
			rest_q <= ppc_pkg::REST_RESET;
		end else if (wr_en) begin
			if (paddr[2] == ppc_pkg::REG_CD) begin
				cd_q <= pwdata[ppc_pkg::CD_W-1:0];
			end else begin
				rest_q <= pwdata[ppc_pkg::REST_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == ppc_pkg::REG_REST) ? 32'(rest_q) : 32'(cd_q);

	ppc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	ppc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cd             (cd_q),
		.rest           (rest_q),
		.req_type       (req_type),
		.particle_index (particle_index),
		.neighbor_index (neighbor_index),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.vel_x          (vel_x),
		.vel_y          (vel_y),
		.vel_z          (vel_z),
		.is_fluid       (is_fluid),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.result_vel_x   (result_vel_x),
		.result_vel_y   (result_vel_y),
		.result_vel_z   (result_vel_z),
		.collided       (collided)
	);

endmodule

// ===== rtl/core/ppc_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module ppc_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == 64'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= 64'd0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

// ===== rtl/core/ppc_div.sv =====
// Restoring divider for the unit normal: quotient of num * 2^30 by den, one bit per cycle.
`timescale 1ns / 1ps
module ppc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [30:0] quo
);

	logic [31:0] rem_q;
	logic [30:0] sh_q;
	logic [30:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem2;
	logic        take;

	assign rem2 = {rem_q, sh_q[30]};
	assign take = rem2 >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 5'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {2'b00, num[30:1]};
			sh_q  <= {num[0], 30'd0};
			quo_q <= 31'd0;
			cnt_q <= 5'd30;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= 32'(rem2 - {1'b0, den});
			end else begin
				rem_q <= rem2[31:0];
			end
			quo_q <= {quo_q[29:0], take};
			sh_q  <= {sh_q[29:0], 1'b0};
			cnt_q <= cnt_q - 5'd1;
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

// ===== rtl/core/ppc_dp.sv =====
// Datapath: particle memories, shared multiplier, root and divider units, result register.
`timescale 1ns / 1ps
module ppc_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ppc_pkg::cmd_t               cmd,
	output ppc_pkg::stat_t              status,
	input  logic [ppc_pkg::CD_W-1:0]    cd,
	input  logic [ppc_pkg::REST_W-1:0]  rest,
	input  logic [1:0]                  req_type,
	input  logic [ppc_pkg::IDX_W-1:0]   particle_index,
	input  logic [ppc_pkg::IDX_W-1:0]   neighbor_index,
	input  logic signed [31:0]          pos_x,
	input  logic signed [31:0]          pos_y,
	input  logic signed [31:0]          pos_z,
	input  logic signed [31:0]          vel_x,
	input  logic signed [31:0]          vel_y,
	input  logic signed [31:0]          vel_z,
	input  logic                        is_fluid,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic signed [31:0]          result_vel_x,
	output logic signed [31:0]          result_vel_y,
	output logic signed [31:0]          result_vel_z,
	output logic                        collided
);

	localparam logic [35:0] DV_CAP = 36'h2_0000_0000;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -36'sh0_8000_0000) begin
			r = -32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	logic [1:0]                  type_q;
	logic [ppc_pkg::IDX_W-1:0]   i_q;
	logic [ppc_pkg::IDX_W-1:0]   j_q;
	logic [95:0]                 req_pos_q;
	logic [95:0]                 req_vel_q;
	logic                        req_fluid_q;
	logic                        ok_i;
	logic                        ok_j;
	logic                        valid_i;

	logic [95:0]                 vel_mem [ppc_pkg::MAX_PARTICLES];
	logic [96:0]                 pos_mem [ppc_pkg::MAX_PARTICLES];
	logic [95:0]                 vel_rd_q;
	logic [96:0]                 pos_rd_q;
	logic [ppc_pkg::ADDR_W-1:0]  addr;
	logic [95:0]                 vel_wdata;

	logic signed [31:0]          pi_q [3];
	logic signed [31:0]          pj_q [3];
	logic signed [31:0]          vi_q [3];
	logic signed [31:0]          vj_q [3];
	logic                        fi_q;
	logic                        fj_q;
	logic signed [32:0]          dr_q [3];
	logic signed [32:0]          dv_q [3];
	logic [32:0]                 dr_mag [3];
	logic [32:0]                 dv_mag [3];

	logic [1:0]                  cnt_q;
	logic [1:0]                  sel;
	logic [34:0]                 mul_a;
	logic [30:0]                 mul_b;
	logic                        mul_neg;
	logic [65:0]                 prod_q;
	logic                        neg_q;
	logic [63:0]                 r2_q;
	logic [30:0]                 n_mag_q [3];
	logic                        n_neg_q [3];
	logic signed [35:0]          vn_q;
	logic [35:0]                 neg_vn;
	logic [34:0]                 imp_q;
	logic [35:0]                 dv_m;
	logic [33:0]                 dv_cap;
	logic signed [34:0]          dvi_q [3];
	logic                        hit_q;

	logic                        sqrt_done;
	logic [31:0]                 root;
	logic                        div_done;
	logic [30:0]                 quo;

	logic                        out_valid_q;
	logic signed [31:0]          res_q [3];
	logic                        coll_q;

	assign ok_i = 32'(i_q) < 32'(ppc_pkg::MAX_PARTICLES);
	assign ok_j = 32'(j_q) < 32'(ppc_pkg::MAX_PARTICLES);
	assign valid_i = ok_i && (type_q != ppc_pkg::REQ_COLLIDE || ok_j);
	assign addr = cmd.addr_j ? ppc_pkg::ADDR_W'(j_q) : ppc_pkg::ADDR_W'(i_q);
	assign sel = (cnt_q == 2'd3) ? 2'd2 : cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q      <= req_type;
			i_q         <= particle_index;
			j_q         <= neighbor_index;
			req_pos_q   <= {pos_z, pos_y, pos_x};
			req_vel_q   <= {vel_z, vel_y, vel_x};
			req_fluid_q <= is_fluid;
		end
	end

	always_comb begin
		if (cmd.wr_req) begin
			vel_wdata = req_vel_q;
		end else if (cmd.addr_j) begin
			vel_wdata = {vj_q[2], vj_q[1], vj_q[0]};
		end else begin
			vel_wdata = {vi_q[2], vi_q[1], vi_q[0]};
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.wr_req && ok_i) || cmd.wr_vel) begin
			vel_mem[addr] <= vel_wdata;
		end
		vel_rd_q <= vel_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_req && ok_i) begin
			pos_mem[addr] <= {req_fluid_q, req_pos_q};
		end
		pos_rd_q <= pos_mem[addr];
	end

	always_comb begin
		for (int d = 0; d < 3; d++) begin
			dr_mag[d] = dr_q[d][32] ? 33'(-dr_q[d]) : 33'(dr_q[d]);
			dv_mag[d] = dv_q[d][32] ? 33'(-dv_q[d]) : 33'(dv_q[d]);
		end
	end

	always_comb begin
		mul_a   = 35'd0;
		mul_b   = 31'd0;
		mul_neg = 1'b0;
		if (cmd.sq) begin
			mul_a = (cnt_q == 2'd3) ? 35'(cd) : 35'(dr_mag[sel][30:0]);
			mul_b = (cnt_q == 2'd3) ? cd : dr_mag[sel][30:0];
		end else if (cmd.dot) begin
			mul_a   = 35'(dv_mag[sel]);
			mul_b   = n_mag_q[sel];
			mul_neg = dv_q[sel][32] ^ n_neg_q[sel];
		end else if (cmd.imp) begin
			mul_a = 35'(neg_vn[33:0]);
			mul_b = 31'(18'(rest) + 18'd65536);
		end else if (cmd.dv) begin
			mul_a   = imp_q;
			mul_b   = n_mag_q[sel];
			mul_neg = n_neg_q[sel];
		end
	end

	assign neg_vn = 36'(-vn_q);
	assign dv_m = prod_q[65:30];
	assign dv_cap = (dv_m > DV_CAP) ? DV_CAP[33:0] : dv_m[33:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= 2'd0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq || cmd.dot || cmd.imp || cmd.dv) begin
			prod_q <= {31'd0, mul_a} * {35'd0, mul_b};
			neg_q  <= mul_neg;
		end
		if (cmd.sq) begin
			r2_q <= (cnt_q == 2'd0) ? 64'd0 : r2_q + prod_q[63:0];
		end
		if (cmd.dot) begin
			if (cnt_q == 2'd0) begin
				vn_q <= 36'sd0;
			end else if (neg_q) begin
				vn_q <= vn_q - $signed({3'd0, prod_q[62:30]});
			end else begin
				vn_q <= vn_q + $signed({3'd0, prod_q[62:30]});
			end
		end
		if (cmd.imp_latch) begin
			imp_q <= prod_q[51:17];
		end
		if (cmd.dv && cnt_q != 2'd0) begin
			dvi_q[cnt_q - 2'd1] <= neg_q ? -$signed({1'b0, dv_cap}) : $signed({1'b0, dv_cap});
		end
		if (div_done) begin
			n_mag_q[sel] <= quo;
			n_neg_q[sel] <= dr_q[sel][32];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_req) begin
			for (int d = 0; d < 3; d++) begin
				vi_q[d] <= ok_i ? req_vel_q[32*d +: 32] : 32'sd0;
			end
		end
		if (cmd.cap_i) begin
			for (int d = 0; d < 3; d++) begin
				pi_q[d] <= pos_rd_q[32*d +: 32];
				vi_q[d] <= valid_i ? vel_rd_q[32*d +: 32] : 32'sd0;
			end
			fi_q <= valid_i & pos_rd_q[96];
		end
		if (cmd.cap_j) begin
			for (int d = 0; d < 3; d++) begin
				pj_q[d] <= pos_rd_q[32*d +: 32];
				vj_q[d] <= vel_rd_q[32*d +: 32];
			end
			fj_q <= pos_rd_q[96];
		end
		if (cmd.diff) begin
			for (int d = 0; d < 3; d++) begin
				dr_q[d] <= {pj_q[d][31], pj_q[d]} - {pi_q[d][31], pi_q[d]};
				dv_q[d] <= {vj_q[d][31], vj_q[d]} - {vi_q[d][31], vi_q[d]};
			end
		end
		if (cmd.upd) begin
			for (int d = 0; d < 3; d++) begin
				vi_q[d] <= sat32(36'(vi_q[d]) - 36'(dvi_q[d]));
				vj_q[d] <= sat32(36'(vj_q[d]) + 36'(dvi_q[d]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hit_q <= 1'b0;
		end else if (cmd.upd) begin
			hit_q <= 1'b1;
		end
	end

	ppc_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (r2_q),
		.done     (sqrt_done),
		.root     (root)
	);

	ppc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (dr_mag[sel][30:0]),
		.den    (root),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			for (int d = 0; d < 3; d++) begin
				res_q[d] <= vi_q[d];
			end
			coll_q <= hit_q;
		end
	end

	always_comb begin
		status.req_type  = ppc_pkg::req_t'(type_q);
		status.fluid_i   = fi_q;
		status.fluid_j   = fj_q;
		status.near      = (dr_mag[0] < 33'(cd)) && (dr_mag[1] < 33'(cd)) &&
		                   (dr_mag[2] < 33'(cd));
		status.r2_ok     = (r2_q != 64'd0) && (r2_q < prod_q[63:0]);
		status.sqrt_done = sqrt_done;
		status.div_done  = div_done;
		status.cnt_two   = cnt_q == 2'd2;
		status.cnt_last  = cnt_q == 2'd3;
		status.vn_neg    = vn_q[35];
		status.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid    = out_valid_q;
	assign result_vel_x = res_q[0];
	assign result_vel_y = res_q[1];
	assign result_vel_z = res_q[2];
	assign collided     = coll_q;

endmodule

// ===== rtl/core/ppc_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps
module ppc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ppc_pkg::stat_t  status,
	output ppc_pkg::cmd_t   cmd
);

	typedef enum logic [19:0] {
		S_IDLE  = 20'h00001,
		S_RDI   = 20'h00002,
		S_RDJ   = 20'h00004,
		S_CAPJ  = 20'h00008,
		S_DIFF  = 20'h00010,
		S_CHK   = 20'h00020,
		S_SQ    = 20'h00040,
		S_CMP   = 20'h00080,
		S_SQRTW = 20'h00100,
		S_DIVGO = 20'h00200,
		S_DIVW  = 20'h00400,
		S_DOT   = 20'h00800,
		S_VN    = 20'h01000,
		S_IMP   = 20'h02000,
		S_IMPL  = 20'h04000,
		S_DV    = 20'h08000,
		S_UPD   = 20'h10000,
		S_WBI   = 20'h20000,
		S_WBJ   = 20'h40000,
		S_FIN   = 20'h80000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RDI;
				end
			end
			S_RDI: begin
				if (status.req_type == ppc_pkg::REQ_WRITE) begin
					cmd.wr_req = 1'b1;
					state_d    = S_FIN;
				end else begin
					state_d = S_RDJ;
				end
			end
			S_RDJ: begin
				cmd.addr_j = 1'b1;
				cmd.cap_i  = 1'b1;
				state_d    = (status.req_type == ppc_pkg::REQ_COLLIDE) ? S_CAPJ : S_FIN;
			end
			S_CAPJ: begin
				cmd.cap_j = 1'b1;
				state_d   = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = status.fluid_i ? S_CHK : S_FIN;
			end
			S_CHK: begin
				cmd.cnt_clr = 1'b1;
				state_d     = status.near ? S_SQ : S_FIN;
			end
			S_SQ: begin
				cmd.sq      = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (status.cnt_last) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (status.r2_ok) begin
					cmd.sqrt_start = 1'b1;
					state_d        = S_SQRTW;
				end else begin
					state_d = S_FIN;
				end
			end
			S_SQRTW: begin
				if (status.sqrt_done) begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_DIVGO;
				end
			end
			S_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVW;
			end
			S_DIVW: begin
				if (status.div_done) begin
					if (status.cnt_two) begin
						cmd.cnt_clr = 1'b1;
						state_d     = S_DOT;
					end else begin
						cmd.cnt_inc = 1'b1;
						state_d     = S_DIVGO;
					end
				end
			end
			S_DOT: begin
				cmd.dot     = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (status.cnt_last) begin
					state_d = S_VN;
				end
			end
			S_VN: begin
				state_d = status.vn_neg ? S_IMP : S_FIN;
			end
			S_IMP: begin
				cmd.imp = 1'b1;
				state_d = S_IMPL;
			end
			S_IMPL: begin
				cmd.imp_latch = 1'b1;
				cmd.cnt_clr   = 1'b1;
				state_d       = S_DV;
			end
			S_DV: begin
				cmd.dv      = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (status.cnt_last) begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_WBI;
			end
			S_WBI: begin
				cmd.wr_vel = 1'b1;
				state_d    = status.fluid_j ? S_WBJ : S_FIN;
			end
			S_WBJ: begin
				cmd.wr_vel = 1'b1;
				cmd.addr_j = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the particle pair collision block with an in-bench velocity predictor.
`timescale 1ns / 1ps
module testbench;

	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam logic [2:0] ADDR_CD = 3'd0;
	localparam logic [2:0] ADDR_REST = 3'd4;
	localparam int POOL_N = 24;

	typedef struct {
		logic [1:0] kind;
		logic [ppc_pkg::IDX_W-1:0] pi;
		logic [ppc_pkg::IDX_W-1:0] nj;
		logic signed [31:0] px, py, pz, vx, vy, vz;
		logic fl;
	} particle_req_t;

	typedef struct {
		logic signed [31:0] vx, vy, vz;
		logic hit;
	} velocity_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] req_type = '0;
	logic [ppc_pkg::IDX_W-1:0] particle_index = '0, neighbor_index = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
	logic is_fluid = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] result_vel_x, result_vel_y, result_vel_z;
	logic collided;

	particle_pair_collision DUT (.*);

	logic signed [31:0] tbl_px [ppc_pkg::MAX_PARTICLES];
	logic signed [31:0] tbl_py [ppc_pkg::MAX_PARTICLES];
	logic signed [31:0] tbl_pz [ppc_pkg::MAX_PARTICLES];
	logic signed [31:0] tbl_vx [ppc_pkg::MAX_PARTICLES];
	logic signed [31:0] tbl_vy [ppc_pkg::MAX_PARTICLES];
	logic signed [31:0] tbl_vz [ppc_pkg::MAX_PARTICLES];
	logic tbl_fl [ppc_pkg::MAX_PARTICLES];
	logic was_loaded [ppc_pkg::MAX_PARTICLES];
	int loaded_list [$];
	logic [ppc_pkg::CD_W-1:0] cd_reg = ppc_pkg::CD_RESET;
	logic [ppc_pkg::REST_W-1:0] rest_reg = ppc_pkg::REST_RESET;

	velocity_res_t pending_vel [$];
	int errors = 0;
	int items_sent = 0;
	int hits_predicted = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int hold_len = 0;
	int pool [POOL_N];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#30ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [63:0] mag(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] res, b;
		res = '0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint mul_q30(longint a, longint b);
		longint m;
		m = longint'((mag(a) * mag(b)) >> 30);
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic logic apply_pair_impulse(int i, int j);
		longint dr [3], dv [3], nrm [3], dvel [3];
		longint vn, rr;
		logic [63:0] r2, cd2, imp, m;
		logic [127:0] prod;
		if (!tbl_fl[i]) return 1'b0;
		dr[0] = longint'(tbl_px[j]) - longint'(tbl_px[i]);
		dr[1] = longint'(tbl_py[j]) - longint'(tbl_py[i]);
		dr[2] = longint'(tbl_pz[j]) - longint'(tbl_pz[i]);
		dv[0] = longint'(tbl_vx[j]) - longint'(tbl_vx[i]);
		dv[1] = longint'(tbl_vy[j]) - longint'(tbl_vy[i]);
		dv[2] = longint'(tbl_vz[j]) - longint'(tbl_vz[i]);
		for (int d = 0; d < 3; d++)
			if (mag(dr[d]) >= 64'(cd_reg)) return 1'b0;
		r2 = '0;
		for (int d = 0; d < 3; d++) r2 = r2 + mag(dr[d]) * mag(dr[d]);
		cd2 = 64'(cd_reg) * 64'(cd_reg);
		if (r2 == 0 || r2 >= cd2) return 1'b0;
		rr = longint'(int_sqrt(r2));
		vn = 0;
		for (int d = 0; d < 3; d++) begin
			nrm[d] = (dr[d] * 64'sd1073741824) / rr;
			vn = vn + mul_q30(dv[d], nrm[d]);
		end
		if (vn >= 0) return 1'b0;
		imp = ((64'd65536 + 64'(rest_reg)) * 64'(-vn)) >> 17;
		for (int d = 0; d < 3; d++) begin
			prod = 128'(imp) * 128'(mag(nrm[d]));
			m = (prod >> 30) > 128'(64'd1 << 33) ? (64'd1 << 33) : 64'(prod >> 30);
			dvel[d] = nrm[d] < 0 ? -longint'(m) : longint'(m);
		end
		tbl_vx[i] = sat32(longint'(tbl_vx[i]) - dvel[0]);
		tbl_vy[i] = sat32(longint'(tbl_vy[i]) - dvel[1]);
		tbl_vz[i] = sat32(longint'(tbl_vz[i]) - dvel[2]);
		if (tbl_fl[j]) begin
			tbl_vx[j] = sat32(longint'(tbl_vx[j]) + dvel[0]);
			tbl_vy[j] = sat32(longint'(tbl_vy[j]) + dvel[1]);
			tbl_vz[j] = sat32(longint'(tbl_vz[j]) + dvel[2]);
		end
		return 1'b1;
	endfunction

	function automatic velocity_res_t predict_velocity(particle_req_t it);
		velocity_res_t r;
		int i;
		i = int'(it.pi);
		r.hit = 1'b0;
		if (it.kind == ppc_pkg::REQ_WRITE) begin
			tbl_px[i] = it.px;
			tbl_py[i] = it.py;
			tbl_pz[i] = it.pz;
			tbl_vx[i] = it.vx;
			tbl_vy[i] = it.vy;
			tbl_vz[i] = it.vz;
			tbl_fl[i] = it.fl;
			if (!was_loaded[i]) loaded_list.push_back(i);
			was_loaded[i] = 1'b1;
		end else if (it.kind == ppc_pkg::REQ_COLLIDE) begin
			r.hit = apply_pair_impulse(i, int'(it.nj));
		end
		r.vx = tbl_vx[i];
		r.vy = tbl_vy[i];
		r.vz = tbl_vz[i];
		return r;
	endfunction

	function automatic particle_req_t make_write(int i, longint px, longint py, longint pz,
			longint vx, longint vy, longint vz, logic fl);
		particle_req_t it;
		it.kind = ppc_pkg::REQ_WRITE;
		it.pi = i[ppc_pkg::IDX_W-1:0];
		it.nj = ppc_pkg::IDX_W'($urandom);
		it.px = px[31:0];
		it.py = py[31:0];
		it.pz = pz[31:0];
		it.vx = vx[31:0];
		it.vy = vy[31:0];
		it.vz = vz[31:0];
		it.fl = fl;
		return it;
	endfunction

	function automatic particle_req_t make_op(logic [1:0] kind, int i, int j);
		particle_req_t it;
		it = make_write(i, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			1'($urandom));
		it.kind = kind;
		it.nj = j[ppc_pkg::IDX_W-1:0];
		return it;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic send_item(particle_req_t it);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= it.kind;
		particle_index <= it.pi;
		neighbor_index <= it.nj;
		pos_x <= it.px;
		pos_y <= it.py;
		pos_z <= it.pz;
		vel_x <= it.vx;
		vel_y <= it.vy;
		vel_z <= it.vz;
		is_fluid <= it.fl;
		do @(posedge clk); while (!in_ready);
		pending_vel.push_back(predict_velocity(it));
		if (pending_vel[$].hit) hits_predicted++;
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_vel.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_CD) cd_reg = data[ppc_pkg::CD_W-1:0];
		else rest_reg = data[ppc_pkg::REST_W-1:0];
		@(posedge clk);
	endtask

	task automatic apb_check(logic [2:0] addr, logic [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata != want) report_mismatch("register read", prdata, want);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [30:0] cd, logic [16:0] e);
		wait_drained();
		apb_write(ADDR_CD, {1'b0, cd});
		apb_write(ADDR_REST, {15'b0, e});
		apb_check(ADDR_CD, {1'b0, cd});
		apb_check(ADDR_REST, {15'b0, e});
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_len > 0) begin
			hold_len = hold_len - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		velocity_res_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_vel.size() == 0) begin
				report_mismatch("beat with nothing pending", result_vel_x, 32'h0);
			end else begin
				w = pending_vel.pop_front();
				if (result_vel_x != w.vx) report_mismatch("result_vel_x", result_vel_x, w.vx);
				if (result_vel_y != w.vy) report_mismatch("result_vel_y", result_vel_y, w.vy);
				if (result_vel_z != w.vz) report_mismatch("result_vel_z", result_vel_z, w.vz);
				if (collided != w.hit) report_mismatch("collided", 32'(collided), 32'(w.hit));
			end
		end
	end

	task automatic test_table_access();
		send_item(make_write(4095, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 1'b1));
		send_item(make_write(4094, 64'sd2147482647, 64'sd2147483647, 64'sd2147483647,
			64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 1'b1));
		send_item(make_write(0, 0, 0, 0, 1000000, 0, 0, 1'b1));
		send_item(make_write(1, 40000, 0, 0, -1000000, 0, 0, 1'b1));
		send_item(make_write(2, 30000, 30000, 10000, -500000, -400000, 0, 1'b0));
		send_item(make_write(3, 0, 0, 0, 5, 6, 7, 1'b1));
		send_item(make_write(4, 1 << 24, 0, 0, -9000000, 0, 0, 1'b1));
		send_item(make_write(5, -40000, 0, 0, -3000000, 0, 0, 1'b1));
		send_item(make_op(ppc_pkg::REQ_READ, 4095, 0));
		send_item(make_op(REQ_SPARE, 0, 4095));
	endtask

	task automatic test_collision_cases();
		send_item(make_op(ppc_pkg::REQ_COLLIDE, 0, 1));
		send_item(make_op(ppc_pkg::REQ_COLLIDE, 0, 2));
		send_item(make_op(ppc_pkg::REQ_COLLIDE, 2, 0));
		send_item(make_op(ppc_pkg::REQ_COLLIDE, 0, 3));
		send_item(make_op(ppc_pkg::REQ_COLLIDE, 0, 4));
		send_item(make_op(ppc_pkg::REQ_COLLIDE, 0, 5));
		send_item(make_op(ppc_pkg::REQ_COLLIDE, 1, 1));
		send_item(make_op(ppc_pkg::REQ_READ, 1, 0));
		set_config(31'h7FFFFFFF, 17'd65536);
		send_item(make_op(ppc_pkg::REQ_COLLIDE, 4094, 4095));
		send_item(make_op(ppc_pkg::REQ_COLLIDE, 4095, 4094));
		send_item(make_op(ppc_pkg::REQ_READ, 4094, 0));
		send_item(make_op(ppc_pkg::REQ_COLLIDE, 0, 1));
		send_item(make_op(ppc_pkg::REQ_COLLIDE, 2, 4095));
	endtask

	task automatic test_random_traffic(int n, logic [30:0] cd, logic [16:0] e);
		longint span, cx, cy, cz, vs;
		int base, pick, a, b;
		particle_req_t it;
		set_config(cd, e);
		span = (cd == 0) ? 64'sd2000 : (cd > 31'h20000000 ? 64'sd536870912 : longint'(cd));
		cx = longint'($urandom_range(32'h7FFFFFFF)) - 64'sd1073741824;
		cy = longint'($urandom_range(32'h7FFFFFFF)) - 64'sd1073741824;
		cz = longint'($urandom_range(32'h7FFFFFFF)) - 64'sd1073741824;
		base = $urandom_range(4095);
		for (int k = 0; k < POOL_N; k++) pool[k] = (base + k * 7) % ppc_pkg::MAX_PARTICLES;
		for (int k = 0; k < POOL_N + n; k++) begin
			pick = $urandom_range(99);
			a = pool[$urandom_range(POOL_N - 1)];
			b = pool[$urandom_range(POOL_N - 1)];
			vs = ($urandom_range(3) == 0) ? 64'sd4294967295 : 64'sd8388607;
			if (k < POOL_N || pick < 25) begin
				if (k < POOL_N) a = pool[k];
				else if (pick < 3) a = $urandom_range(4095);
				it = make_write(a,
					cx + longint'($urandom_range(32'(span))) - span / 2,
					cy + longint'($urandom_range(32'(span))) - span / 2,
					cz + longint'($urandom_range(32'(span))) - span / 2,
					longint'($urandom_range(32'(vs))) - vs / 2,
					longint'($urandom_range(32'(vs))) - vs / 2,
					longint'($urandom_range(32'(vs))) - vs / 2,
					$urandom_range(5) != 0);
				if (pick < 6 && k >= POOL_N)
					it = make_write(a, $urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom, 1'($urandom));
			end else if (pick < 80) begin
				if (pick < 30) b = loaded_list[$urandom_range(loaded_list.size() - 1)];
				it = make_op(ppc_pkg::REQ_COLLIDE, a, b);
			end else begin
				if (pick < 88) a = loaded_list[$urandom_range(loaded_list.size() - 1)];
				it = make_op(pick < 95 ? ppc_pkg::REQ_READ : REQ_SPARE, a, b);
			end
			if (k == POOL_N + n / 2) hold_len = 400;
			send_item(it);
		end
	endtask

	task automatic test_backpressure();
		hold_len = 600;
		for (int k = 0; k < 12; k++)
			send_item(make_op(ppc_pkg::REQ_COLLIDE, pool[k], pool[k + 1]));
		wait_drained();
		for (int k = 0; k < 6; k++) send_item(make_op(ppc_pkg::REQ_READ, pool[k], 0));
	endtask

	initial begin
		for (int k = 0; k < ppc_pkg::MAX_PARTICLES; k++) begin
			tbl_px[k] = '0; tbl_py[k] = '0; tbl_pz[k] = '0;
			tbl_vx[k] = '0; tbl_vy[k] = '0; tbl_vz[k] = '0;
			tbl_fl[k] = 1'b0; was_loaded[k] = 1'b0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_check(ADDR_CD, {1'b0, ppc_pkg::CD_RESET});
		apb_check(ADDR_REST, {15'b0, ppc_pkg::REST_RESET});
		test_table_access();
		set_config(ppc_pkg::CD_RESET, ppc_pkg::REST_RESET);
		test_collision_cases();
		send_idle = 13; recv_idle = 54;
		test_random_traffic(205, ppc_pkg::CD_RESET, ppc_pkg::REST_RESET);
		test_random_traffic(205, 31'd0, 17'd65536);
		send_idle = 54; recv_idle = 13;
		test_random_traffic(205, 31'h7FFFFFFF, 17'd0);
		test_random_traffic(205, 31'($urandom_range(32'h01000000)), 17'($urandom_range(65536)));
		send_idle = 0; recv_idle = 0;
		test_random_traffic(205, 31'd2000000, 17'd65536);
		test_backpressure();
		test_random_traffic(205, 31'd1, 17'($urandom_range(65536)));
		wait_drained();
		repeat (200) @(posedge clk);
		$display("Sent %0d requests: writes, reads, spare codes and pair collisions", items_sent);
		$display("under seven register settings; %0d pairs predicted to collide", hits_predicted);
		if (errors == 0 && pending_vel.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
